@@ hw/rtl/mvm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types, codes and constants of the matrix-vector multiply block.
// ----------------------------------------------------------------------------
package mvm_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // Field widths of the stream items.
    localparam int IDX_W   = 6;
    localparam int VAL_W   = 16;
    localparam int DOT_W   = 32;
    localparam int CNT_W   = 7;
    localparam int PROD_W  = 2 * VAL_W;
    // Up to 64 products of at most 2^30 in magnitude.
    localparam int ACC_W   = 40;
    localparam int REG_IDX_W = 2;

    localparam logic CMD_WEIGHT = 1'b0;
    localparam logic CMD_VECTOR = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } mvm_state_t;

    typedef struct packed {
        logic             wr_weight;
        logic             wr_vector;
        logic             issue;
        logic             first;
        logic             load_out;
        logic             out_last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } mvm_cmd_t;

    typedef struct packed {
        logic out_free;
    } mvm_stat_t;

endpackage

@@ hw/rtl/mvm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/mvm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_ctrl
// Controller: configuration registers, input acceptance and the row/column
// sequencer that drives the shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module mvm_ctrl
    import mvm_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_cmd,
    input  logic [IDX_W-1:0]     in_row,
    input  logic [IDX_W-1:0]     in_col,
    input  mvm_stat_t            stat,
    output mvm_cmd_t             cmd
);

    localparam int VD = (MAX_COLS < 64) ? MAX_COLS : 64;

    mvm_state_t       state_reg, state_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic             drain_reg, drain_next;
    logic [CNT_W-1:0] row_count_reg, col_count_reg;
    logic [CNT_W-1:0] nr, nc;
    logic [IDX_W-1:0] last_row, last_col;
    logic             accept, row_ok, col_ok, trigger;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CNT_W'(64);
            col_count_reg <= CNT_W'(64);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROW_COUNT: row_count_reg <= cfg_data;
                REG_COL_COUNT: col_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Out-of-range counts are clamped into the usable range.
    always_comb
    begin
        if (row_count_reg == '0)
            nr = CNT_W'(1);
        else if (row_count_reg > CNT_W'(MAX_ROWS))
            nr = CNT_W'(MAX_ROWS);
        else
            nr = row_count_reg;

        if (col_count_reg == '0)
            nc = CNT_W'(1);
        else if (col_count_reg > CNT_W'(VD))
            nc = CNT_W'(VD);
        else
            nc = col_count_reg;
    end

    assign last_row = IDX_W'(nr - CNT_W'(1));
    assign last_col = IDX_W'(nc - CNT_W'(1));

    assign accept  = in_valid && in_ready;
    assign row_ok  = int'(in_row) < MAX_ROWS;
    assign col_ok  = int'(in_col) < MAX_COLS;
    assign trigger = accept && (in_cmd == CMD_VECTOR) && col_ok && (in_col == last_col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            drain_reg <= drain_next;
        end
    end

    // Next state: each row issues its columns, waits in the drain state for the
    // multiply and accumulate stages, then hands the sum to the output register.
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        drain_next = drain_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (trigger)
                begin
                    state_next = ST_RUN;
                    row_next   = '0;
                    col_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (col_reg == last_col)
                begin
                    state_next = ST_DRAIN;
                    drain_next = 1'b0;
                end
                else
                begin
                    col_next = col_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    if (row_reg == last_row)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                        row_next   = row_reg + IDX_W'(1);
                        col_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The input is always ready in idle, so a valid item there is accepted.
    always_comb
    begin
        in_ready      = 1'b0;
        cmd.wr_weight = 1'b0;
        cmd.wr_vector = 1'b0;
        cmd.issue     = 1'b0;
        cmd.first     = (col_reg == '0);
        cmd.load_out  = 1'b0;
        cmd.out_last  = (row_reg == last_row);
        cmd.row       = row_reg;
        cmd.col       = col_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.wr_weight = in_valid && (in_cmd == CMD_WEIGHT) && row_ok && col_ok;
                cmd.wr_vector = in_valid && (in_cmd == CMD_VECTOR) && col_ok;
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN: ;
            ST_EMIT:
            begin
                cmd.load_out = stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

@@ hw/rtl/mvm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_datapath
// Weight and vector memories, the shared multiply-accumulate pipeline and
// the saturating output register.
// ----------------------------------------------------------------------------
module mvm_datapath
    import mvm_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mvm_cmd_t                cmd,
    output mvm_stat_t               stat,
    input  logic [IDX_W-1:0]        in_row,
    input  logic [IDX_W-1:0]        in_col,
    input  logic signed [VAL_W-1:0] in_value,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [IDX_W-1:0]        out_row_index,
    output logic signed [DOT_W-1:0] out_dot,
    output logic                    out_last
);

    localparam int WD   = MAX_ROWS * MAX_COLS;
    localparam int WA_W = (WD > 1) ? $clog2(WD) : 1;
    localparam int VD   = (MAX_COLS < 64) ? MAX_COLS : 64;
    localparam int VA_W = (VD > 1) ? $clog2(VD) : 1;

    logic [WA_W-1:0]          w_wr_addr, w_rd_addr;
    logic [VAL_W-1:0]         w_rd_data, v_rd_data;
    logic                     s1_valid_reg, s1_first_reg;
    logic                     s2_valid_reg, s2_first_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DOT_W-1:0]  sat_dot;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg;
    logic signed [DOT_W-1:0]  out_dot_reg;
    logic                     out_last_reg;

    assign w_wr_addr = WA_W'(int'(in_row) * MAX_COLS + int'(in_col));
    assign w_rd_addr = WA_W'(int'(cmd.row) * MAX_COLS + int'(cmd.col));

    mvm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (WD)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_weight),
        .wr_addr (w_wr_addr),
        .wr_data (in_value),
        .rd_en   (cmd.issue),
        .rd_addr (w_rd_addr),
        .rd_data (w_rd_data)
    );

    mvm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (VD)
    ) u_vector_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_vector),
        .wr_addr (in_col[VA_W-1:0]),
        .wr_data (in_value),
        .rd_en   (cmd.issue),
        .rd_addr (cmd.col[VA_W-1:0]),
        .rd_data (v_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first;
        s2_first_reg <= s1_first_reg;
        if (s1_valid_reg)
        begin
            prod_reg <= $signed(w_rd_data) * $signed(v_rd_data);
        end
        // The first column of a row restarts the sum.
        if (s2_valid_reg)
        begin
            acc_reg <= (s2_first_reg ? '0 : acc_reg)
                     + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_comb
    begin
        if (!acc_reg[ACC_W-1] && (|acc_reg[ACC_W-2:DOT_W-1]))
            sat_dot = {1'b0, {(DOT_W-1){1'b1}}};
        else if (acc_reg[ACC_W-1] && !(&acc_reg[ACC_W-2:DOT_W-1]))
            sat_dot = {1'b1, {(DOT_W-1){1'b0}}};
        else
            sat_dot = acc_reg[DOT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_row_reg  <= cmd.row;
            out_dot_reg  <= sat_dot;
            out_last_reg <= cmd.out_last;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_row_index = out_row_reg;
    assign out_dot       = out_dot_reg;
    assign out_last      = out_last_reg;

endmodule

@@ hw/rtl/matrix_vector_multiply_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_multiply_core
// Stores a Q8.8 weight matrix and a vector, and on the last vector element
// emits one saturated Q16.16 dot product per row in use.
//
//   Channel  Direction  Handshake                    Payload
//   s_axis   in         s_axis_tvalid/s_axis_tready  tdata, tuser = cmd
//   m_axis   out        m_axis_tvalid/m_axis_tready  tdata, tlast = last
//   cfg      in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// A weight item or a vector element that does not complete the vector is
// accepted whenever the core is idle. The completing element starts a run
// in which one shared multiplier does one column per cycle and each row's
// sum is handed to the output register. No input item is taken in that run.
// Reset clears the control state and sets both counts to 64; the memories
// are not cleared. A stalled output holds the sequencer at the end of a row.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_core
    import mvm_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // row[5:0], col[11:6], value[27:12]
    input  logic                 s_axis_tuser,  // cmd[0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,  // row_index[5:0], dot[37:6]
    output logic                 m_axis_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    mvm_cmd_t                cmd;
    mvm_stat_t               stat;
    logic [IDX_W-1:0]        in_row, in_col, out_row_index;
    logic signed [VAL_W-1:0] in_value;
    logic signed [DOT_W-1:0] out_dot;

    assign in_row   = s_axis_tdata[5:0];
    assign in_col   = s_axis_tdata[11:6];
    assign in_value = s_axis_tdata[27:12];

    mvm_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tuser),
        .in_row    (in_row),
        .in_col    (in_col),
        .stat      (stat),
        .cmd       (cmd)
    );

    mvm_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_row        (in_row),
        .in_col        (in_col),
        .in_value      (in_value),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_row_index (out_row_index),
        .out_dot       (out_dot),
        .out_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_dot, out_row_index};

endmodule

@@ bench/mvm_dot_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_dot_checker
// Watches the configuration, input and result channels of the matrix-vector
// multiply core. It keeps its own copy of the weights, the vector and the
// counts, and predicts one saturated dot product per row in use whenever the
// completing vector element is taken. It then compares each result item,
// field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module mvm_dot_checker
    import mvm_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,
    input  logic                 s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [39:0]          m_axis_tdata,
    input  logic                 m_axis_tlast,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   outstanding
);

    localparam int     COL_LIMIT  = (MAX_COLS < 64) ? MAX_COLS : 64;
    localparam longint DOT_MAX    = (longint'(1) <<< (DOT_W - 1)) - 1;
    localparam longint DOT_MIN    = -(longint'(1) <<< (DOT_W - 1));
    localparam int     REPORT_CAP = 200;

    typedef struct packed {
        logic [IDX_W-1:0]        row_index;
        logic signed [DOT_W-1:0] dot;
        logic                    last;
    } row_dot_t;

    logic signed [VAL_W-1:0] weight_mem [MAX_ROWS*MAX_COLS];
    logic signed [VAL_W-1:0] vector_mem [MAX_COLS];
    logic [CNT_W-1:0]        row_count_reg;
    logic [CNT_W-1:0]        col_count_reg;
    row_dot_t                pending_dots [$];
    int                      fails = 0;
    int                      queued = 0;

    assign fail_count  = fails;
    assign outstanding = queued;

    // A count of zero means one, and anything past the array size is cut back.
    function automatic int clamp_count(input logic [CNT_W-1:0] v, input int limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    function automatic logic signed [DOT_W-1:0] saturated_row_dot(input int r, input int nc);
        longint acc;
        acc = 0;
        for (int c = 0; c < nc; c++)
            acc += longint'(weight_mem[r*MAX_COLS + c]) * longint'(vector_mem[c]);
        if (acc > DOT_MAX)
            acc = DOT_MAX;
        if (acc < DOT_MIN)
            acc = DOT_MIN;
        return acc[DOT_W-1:0];
    endfunction

    // The count keeps going past the cap so that the verdict stays right.
    task automatic note_mismatch(input string field, input string want_s, input string got_s);
        fails++;
        if (fails <= REPORT_CAP)
            $display("%0t ns: %s mismatch, expected %s, actual %s", $time, field, want_s, got_s);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        row_dot_t         got;
        row_dot_t         want;
        logic [IDX_W-1:0] item_row;
        logic [IDX_W-1:0] item_col;
        logic [VAL_W-1:0] item_val;
        int               nr;
        int               nc;

        if (!rst_n)
        begin
            row_count_reg = CNT_W'(64);
            col_count_reg = CNT_W'(64);
            pending_dots.delete();
            queued = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.row_index = m_axis_tdata[IDX_W-1:0];
                got.dot       = m_axis_tdata[IDX_W +: DOT_W];
                got.last      = m_axis_tlast;
                if (pending_dots.size() == 0)
                begin
                    note_mismatch("result", "none",
                                  $sformatf("row_index %0d dot %0d last %0b",
                                            got.row_index, got.dot, got.last));
                end
                else
                begin
                    want = pending_dots.pop_front();
                    if (got.row_index !== want.row_index)
                        note_mismatch("row_index", $sformatf("%0d", want.row_index),
                                      $sformatf("%0d", got.row_index));
                    if (got.dot !== want.dot)
                        note_mismatch($sformatf("dot of row %0d", want.row_index),
                                      $sformatf("%0d", want.dot), $sformatf("%0d", got.dot));
                    if (got.last !== want.last)
                        note_mismatch($sformatf("last of row %0d", want.row_index),
                                      $sformatf("%0b", want.last), $sformatf("%0b", got.last));
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ROW_COUNT)
                    row_count_reg = cfg_data;
                else if (cfg_index == REG_COL_COUNT)
                    col_count_reg = cfg_data;
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                item_row = s_axis_tdata[IDX_W-1:0];
                item_col = s_axis_tdata[IDX_W +: IDX_W];
                item_val = s_axis_tdata[2*IDX_W +: VAL_W];
                if (s_axis_tuser == CMD_WEIGHT)
                begin
                    if (item_row < MAX_ROWS && item_col < MAX_COLS)
                        weight_mem[item_row*MAX_COLS + item_col] = item_val;
                end
                else if (item_col < MAX_COLS)
                begin
                    vector_mem[item_col] = item_val;
                    nc = clamp_count(col_count_reg, COL_LIMIT);
                    // Only the element at the last column in use starts a pass.
                    if (item_col == nc - 1)
                    begin
                        nr = clamp_count(row_count_reg, MAX_ROWS);
                        for (int r = 0; r < nr; r++)
                        begin
                            want.row_index = IDX_W'(r);
                            want.dot       = saturated_row_dot(r, nc);
                            want.last      = (r == nr - 1);
                            pending_dots.push_back(want);
                        end
                    end
                end
            end

            queued = pending_dots.size();
        end
    end

endmodule

@@ bench/matrix_vector_multiply_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_multiply_core_tb
// Drives weight items, vector elements and count writes into the core, with
// random gaps on the input side and random stalls on the result side. A short
// directed sequence covers saturation both ways and the extreme field values;
// random phases then sweep the counts, the extremes and the out-of-range
// settings among them. Results are checked by the dot-product checker.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_core_tb;
    import mvm_pkg::*;

    localparam int ROWS         = DEF_MAX_ROWS;
    localparam int COLS         = DEF_MAX_COLS;
    localparam int RANDOM_ITEMS = 250;
    localparam int CYCLE_LIMIT  = 20000000;
    localparam int LONG_HOLD    = 600;
    localparam int HOLD_AFTER   = 40;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;   // row[5:0], col[11:6], value[27:12]
    logic                 s_axis_tuser;   // cmd[0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [39:0]          m_axis_tdata;   // row_index[5:0], dot[37:6]
    logic                 m_axis_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;
    int                   fail_count;
    int                   outstanding;
    int                   cycle_count = 0;

    // Entries already written, so that no pass ever reads an unwritten one.
    bit weight_set [ROWS*COLS];
    bit vector_set [COLS];

    matrix_vector_multiply_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    mvm_dot_checker dot_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] rand_q88();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0)
            return 16'h8000;
        if (p == 1)
            return 16'h7FFF;
        return VAL_W'($urandom);
    endfunction

    // Mostly back to back or short gaps, now and then a long pause.
    function automatic int sender_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int used_count(input logic [CNT_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > 64)
            return 64;
        return v;
    endfunction

    // Picks, from a random starting point, an entry that the next pass would
    // read but that was never written.
    function automatic bit find_missing(input int nr, input int nc, output logic cmd,
                                        output int row, output int col);
        int start;
        int idx;
        start = $urandom_range(0, nr*nc - 1);
        cmd = CMD_WEIGHT;
        for (int k = 0; k < nr*nc; k++)
        begin
            idx = (start + k) % (nr*nc);
            row = idx / nc;
            col = idx % nc;
            if (!weight_set[row*COLS + col])
                return 1'b1;
        end
        cmd = CMD_VECTOR;
        row = $urandom_range(0, ROWS - 1);
        start = $urandom_range(0, COLS - 1);
        for (int k = 0; k < nc - 1; k++)
        begin
            col = (start + k) % (nc - 1);
            if (!vector_set[col])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_item(input logic cmd, input int row, input int col,
                             input logic [VAL_W-1:0] value);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, value, IDX_W'(col), IDX_W'(row)};
        if (cmd == CMD_WEIGHT)
            weight_set[row*COLS + col] = 1'b1;
        else
            vector_set[col] = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        gap = sender_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_counts(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] cols,
                                  input bit with_spare);
        write_reg(REG_ROW_COUNT, rows);
        if (with_spare)
            write_reg(REG_SPARE, CNT_W'($urandom));
        write_reg(REG_COL_COUNT, cols);
        cfg_valid <= 1'b0;
    endtask

    // Holds the input off until every predicted result has been taken.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        // Weight items and non-final elements are written straight into the memories.
        repeat (8) @(posedge clk);
    endtask

    // Result side: random ready runs and stalls, plus one long hold once
    // results are flowing, so that the core backs up into its input.
    initial
    begin
        int run_left;
        bit run_ready;
        int hold_left;
        int results_taken;
        bit long_hold_done;

        run_left       = 0;
        run_ready      = 1'b0;
        hold_left      = 0;
        results_taken  = 0;
        long_hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!long_hold_done && results_taken >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_ready = ($urandom_range(0, 2) != 0);
                    if (run_ready)
                        run_left = $urandom_range(1, 30);
                    else if ($urandom_range(0, 9) == 0)
                        run_left = $urandom_range(20, 60);
                    else
                        run_left = $urandom_range(1, 3);
                end
                run_left--;
                m_axis_tready <= run_ready;
            end
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                results_taken++;
        end
    end

    initial
    begin
        int               phase;
        int               n_items;
        int               random_items;
        int               nr;
        int               nc;
        int               pick;
        int               row;
        int               col;
        logic             mcmd;
        bit               missing;
        logic [CNT_W-1:0] rows_w;
        logic [CNT_W-1:0] cols_w;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_WEIGHT;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_ROW_COUNT;
        cfg_data      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Two rows of three: row 0 saturates high, row 1 saturates low.
        program_counts(CNT_W'(2), CNT_W'(3), 1'b1);
        send_item(CMD_WEIGHT, 0, 0, 16'h8000);
        send_item(CMD_WEIGHT, 0, 1, 16'h8000);
        send_item(CMD_WEIGHT, 0, 2, 16'h8000);
        send_item(CMD_WEIGHT, 1, 0, 16'h7FFF);
        send_item(CMD_WEIGHT, 1, 1, 16'h7FFF);
        send_item(CMD_WEIGHT, 1, 2, 16'h7FFF);
        send_item(CMD_VECTOR, 0, 0, 16'h8000);
        send_item(CMD_VECTOR, 0, 1, 16'h8000);
        send_item(CMD_VECTOR, 0, 2, 16'h8000);
        // Highest indexes, an element past the columns in use, and a row field
        // that vector elements must ignore.
        send_item(CMD_WEIGHT, 63, 63, 16'h7FFF);
        send_item(CMD_VECTOR, 63, 63, 16'hFFFF);
        send_item(CMD_WEIGHT, 1, 2, 16'h0001);
        send_item(CMD_VECTOR, 63, 2, 16'h0100);
        send_item(CMD_VECTOR, 0, 0, 16'h0000);
        send_item(CMD_VECTOR, 0, 1, 16'h0001);
        send_item(CMD_VECTOR, 0, 2, 16'h7FFF);

        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case (phase)
                0:
                begin
                    rows_w = CNT_W'(64);
                    cols_w = CNT_W'(1);
                end
                1:
                begin
                    rows_w = CNT_W'(1);
                    cols_w = CNT_W'(64);
                end
                // Zero counts as one and anything above 64 counts as 64.
                2:
                begin
                    rows_w = CNT_W'(0);
                    cols_w = CNT_W'(127);
                end
                3:
                begin
                    rows_w = CNT_W'(127);
                    cols_w = CNT_W'(0);
                end
                default:
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        rows_w = CNT_W'(64);
                        cols_w = CNT_W'($urandom_range(1, 2));
                    end
                    else
                    begin
                        rows_w = CNT_W'($urandom_range(1, 8));
                        cols_w = CNT_W'($urandom_range(1, 8));
                    end
                end
            endcase
            nr = used_count(rows_w);
            nc = used_count(cols_w);

            wait_idle();
            program_counts(rows_w, cols_w, (phase % 5 == 4));

            n_items = nr*nc + $urandom_range(15, 35);
            for (int i = 0; i < n_items; i++)
            begin
                missing = find_missing(nr, nc, mcmd, row, col);
                pick    = $urandom_range(0, 99);
                if (missing && pick < 70)
                    send_item(mcmd, row, col, rand_q88());
                else if (!missing && pick < 35)
                    send_item(CMD_VECTOR, $urandom_range(0, ROWS - 1), nc - 1, rand_q88());
                else if (pick < 80)
                begin
                    // Weights are mostly rewritten inside the region in use.
                    if ($urandom_range(0, 9) < 6)
                    begin
                        row = $urandom_range(0, nr - 1);
                        col = $urandom_range(0, nc - 1);
                    end
                    else
                    begin
                        row = $urandom_range(0, ROWS - 1);
                        col = $urandom_range(0, COLS - 1);
                    end
                    send_item(CMD_WEIGHT, row, col, rand_q88());
                end
                else
                begin
                    col = $urandom_range(0, COLS - 1);
                    if (col == nc - 1)
                        col = (col + 1) % COLS;
                    send_item(CMD_VECTOR, $urandom_range(0, ROWS - 1), col, rand_q88());
                end
            end
            if (!find_missing(nr, nc, mcmd, row, col))
                send_item(CMD_VECTOR, $urandom_range(0, ROWS - 1), nc - 1, rand_q88());

            random_items += n_items;
            phase++;
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
